[src/bla_pkg.sv]
`default_nettype none

package bla_pkg;

    localparam int BLA_ITERATIONS = 24;

    localparam int DIST_W  = 18;
    localparam int SPEED_W = 14;
    localparam int HGT_W   = 15;
    localparam int PITCH_W = 17;

    localparam int SQ2_W = 28;
    localparam int DSQ_W = 36;
    localparam int A_W   = 35;
    localparam int S4_W  = 56;
    localparam int DD_W  = 48;
    localparam int SH_W  = 43;
    localparam int DEN_W = 34;
    localparam int RAD_W = 72;

    localparam int ROOT_W = 38;
    localparam int SQ_W   = 2 * ROOT_W;

    localparam int XY_W     = 48;
    localparam int Z_W      = 33;
    localparam int NORM_TOP = 40;
    localparam int NORM_N   = 5;

    localparam int MAG_W  = 31;
    localparam int PROD_W = 62;
    localparam int DEG_W  = 16;

    localparam logic [29:0] DEG_SCALE = 30'd961263669;
    localparam logic signed [PITCH_W-1:0] PITCH_RIGHT = 17'sd23040;
    localparam logic signed [PITCH_W-1:0] PITCH_BAD   = -17'sd256;

    typedef struct packed {
        logic             invalid;
        logic [A_W-1:0]   a;
        logic [DEN_W-1:0] den;
    } t_side;

    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] v;
        case (idx)
            0:  v = 30'd843314857;
            1:  v = 30'd497837829;
            2:  v = 30'd263043837;
            3:  v = 30'd133525159;
            4:  v = 30'd67021687;
            5:  v = 30'd33543516;
            6:  v = 30'd16775851;
            7:  v = 30'd8388437;
            8:  v = 30'd4194283;
            9:  v = 30'd2097149;
            10: v = 30'd1048576;
            11: v = 30'd524288;
            12: v = 30'd262144;
            13: v = 30'd131072;
            14: v = 30'd65536;
            15: v = 30'd32768;
            16: v = 30'd16384;
            17: v = 30'd8192;
            18: v = 30'd4096;
            19: v = 30'd2048;
            20: v = 30'd1024;
            21: v = 30'd512;
            22: v = 30'd256;
            23: v = 30'd128;
            24: v = 30'd64;
            25: v = 30'd32;
            26: v = 30'd16;
            27: v = 30'd8;
            28: v = 30'd4;
            29: v = 30'd2;
            30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[src/bla_front.sv]
`default_nettype none

module bla_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_ce,
    input  logic                               i_valid,
    input  logic [bla_pkg::DIST_W-1:0]         i_distance,
    input  logic [bla_pkg::SPEED_W-1:0]        i_speed,
    input  logic [bla_pkg::HGT_W-1:0]          i_height,
    output logic                               o_valid,
    output logic [bla_pkg::RAD_W-1:0]          o_rad,
    output bla_pkg::t_side                     o_side
);
    import bla_pkg::*;

    logic [4:0] r_v;

    logic             r1_hneg, r1_dz;
    logic [SQ2_W-1:0] r1_s2;
    logic [DSQ_W-1:0] r1_d2;
    logic [DIST_W-1:0] r1_d;
    logic [HGT_W-1:0] r1_habs;

    logic             r2_hneg, r2_dz;
    logic [A_W-1:0]   r2_a;
    logic [S4_W-1:0]  r2_s4;
    logic [DD_W-1:0]  r2_dd;
    logic [SH_W-1:0]  r2_sh;
    logic [DEN_W-1:0] r2_den;

    logic             r3_hneg, r3_dz;
    logic [A_W-1:0]   r3_a;
    logic [DEN_W-1:0] r3_den;
    logic [RAD_W-1:0] r3_pos, r3_neg, r3_t;

    logic             r4_dz;
    logic [A_W-1:0]   r4_a;
    logic [DEN_W-1:0] r4_den;
    logic [RAD_W-1:0] r4_pos, r4_neg;

    logic             r5_inv;
    logic [A_W-1:0]   r5_a;
    logic [DEN_W-1:0] r5_den;
    logic [RAD_W-1:0] r5_rad;

    logic             w_hneg;
    logic [HGT_W-1:0] w_habs;
    logic [RAD_W:0]   w_diff;

    assign w_hneg = i_height[HGT_W-1];
    assign w_habs = w_hneg ? (~i_height + 1'b1) : i_height;
    assign w_diff = {1'b0, r4_pos} - {1'b0, r4_neg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            // squares
            r1_s2   <= SQ2_W'(i_speed) * SQ2_W'(i_speed);
            r1_d2   <= DSQ_W'(i_distance) * DSQ_W'(i_distance);
            r1_d    <= i_distance;
            r1_habs <= w_habs;
            r1_hneg <= w_hneg;
            r1_dz   <= (i_distance == '0);

            r2_a    <= A_W'(r1_s2) * A_W'(125);
            r2_s4   <= S4_W'(r1_s2) * S4_W'(r1_s2);
            r2_dd   <= DD_W'(r1_d2) * DD_W'(2401);
            r2_sh   <= SH_W'(r1_s2) * SH_W'(r1_habs);
            r2_den  <= DEN_W'(r1_d) * DEN_W'(50176);
            r2_hneg <= r1_hneg;
            r2_dz   <= r1_dz;

            // a^2, den^2 and the height term
            r3_pos  <= RAD_W'(r2_s4) * RAD_W'(15625);
            r3_neg  <= RAD_W'(r2_dd) << 20;
            r3_t    <= (RAD_W'(r2_sh) * RAD_W'(4900)) << 12;
            r3_a    <= r2_a;
            r3_den  <= r2_den;
            r3_hneg <= r2_hneg;
            r3_dz   <= r2_dz;

            r4_pos  <= r3_hneg ? r3_pos + r3_t : r3_pos;
            r4_neg  <= r3_hneg ? r3_neg : r3_neg + r3_t;
            r4_a    <= r3_a;
            r4_den  <= r3_den;
            r4_dz   <= r3_dz;

            r5_rad  <= w_diff[RAD_W-1:0];
            r5_inv  <= r4_dz | w_diff[RAD_W];
            r5_a    <= r4_a;
            r5_den  <= r4_den;
        end
    end

    assign o_valid        = r_v[4];
    assign o_rad          = r5_rad;
    assign o_side.invalid = r5_inv;
    assign o_side.a       = r5_a;
    assign o_side.den     = r5_den;

endmodule

`default_nettype wire

[src/bla_sqrt.sv]
`default_nettype none

module bla_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_valid,
    input  logic [bla_pkg::RAD_W-1:0]     i_rad,
    input  bla_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [bla_pkg::ROOT_W-1:0]    o_root,
    output bla_pkg::t_side                o_side
);
    import bla_pkg::*;

    logic [ROOT_W-1:0] r_v;
    logic [SQ_W-1:0]   r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    t_side             r_side [0:ROOT_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[ROOT_W-2:0], i_valid};
        end
    end

    // one root bit per stage, most significant first
    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            localparam int B = ROOT_W - 1 - k;
            logic [SQ_W-1:0]   w_rem_in;
            logic [SQ_W-1:0]   w_trial;
            logic [ROOT_W-1:0] w_root_in;
            t_side             w_side_in;

            if (k == 0) begin : g_first
                assign w_rem_in  = SQ_W'(i_rad);
                assign w_root_in = '0;
                assign w_side_in = i_side;
            end else begin : g_next
                assign w_rem_in  = r_rem[k-1];
                assign w_root_in = r_root[k-1];
                assign w_side_in = r_side[k-1];
            end

            assign w_trial = (SQ_W'(w_root_in) << (B + 1)) | (SQ_W'(1) << (2 * B));

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    if (w_rem_in >= w_trial) begin
                        r_rem[k]  <= w_rem_in - w_trial;
                        r_root[k] <= w_root_in | (ROOT_W'(1) << B);
                    end else begin
                        r_rem[k]  <= w_rem_in;
                        r_root[k] <= w_root_in;
                    end
                    r_side[k] <= w_side_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

`default_nettype wire

[src/bla_cordic.sv]
`default_nettype none

module bla_cordic #(
    parameter int ITERATIONS = bla_pkg::BLA_ITERATIONS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_ce,
    input  logic                              i_valid,
    input  logic [bla_pkg::ROOT_W-1:0]        i_root,
    input  bla_pkg::t_side                    i_side,
    output logic                              o_valid,
    output logic signed [bla_pkg::Z_W-1:0]    o_z,
    output logic                              o_invalid
);
    import bla_pkg::*;

    localparam int DEPTH = 1 + NORM_N + ITERATIONS;

    logic [DEPTH-1:0] r_v;

    logic signed [XY_W-1:0] r_px, r_py;
    logic                   r_pinv;

    logic signed [XY_W-1:0] r_nx [0:NORM_N-1];
    logic signed [XY_W-1:0] r_ny [0:NORM_N-1];
    logic                   r_ninv [0:NORM_N-1];

    logic signed [XY_W-1:0] r_x [0:ITERATIONS-1];
    logic signed [XY_W-1:0] r_y [0:ITERATIONS-1];
    logic signed [Z_W-1:0]  r_z [0:ITERATIONS-1];
    logic                   r_inv [0:ITERATIONS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_px   <= $signed(XY_W'(i_side.den));
            r_py   <= $signed(XY_W'(i_side.a)) - $signed(XY_W'(i_root));
            r_pinv <= i_side.invalid;
        end
    end

    // doubling count found by binary steps of 16, 8, 4, 2, 1
    genvar j;
    generate
        for (j = 0; j < NORM_N; j++) begin : g_norm
            localparam int SH = 1 << (NORM_N - 1 - j);
            localparam logic signed [XY_W-1:0] LIM = XY_W'(64'd1 << (NORM_TOP - SH + 1));
            logic signed [XY_W-1:0] w_x, w_y;
            logic                   w_inv, w_go;

            if (j == 0) begin : g_first
                assign w_x   = r_px;
                assign w_y   = r_py;
                assign w_inv = r_pinv;
            end else begin : g_next
                assign w_x   = r_nx[j-1];
                assign w_y   = r_ny[j-1];
                assign w_inv = r_ninv[j-1];
            end

            assign w_go = (w_x < LIM) && (w_y < LIM) && (w_y > -LIM);

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_nx[j]   <= w_go ? (w_x <<< SH) : w_x;
                    r_ny[j]   <= w_go ? (w_y <<< SH) : w_y;
                    r_ninv[j] <= w_inv;
                end
            end
        end
    endgenerate

    // vectoring rotations
    genvar i;
    generate
        for (i = 0; i < ITERATIONS; i++) begin : g_rot
            localparam logic signed [Z_W-1:0] ANG = $signed(Z_W'(atan_q30(i)));
            logic signed [XY_W-1:0] w_x, w_y, w_xs, w_ys;
            logic signed [Z_W-1:0]  w_z;
            logic                   w_inv;

            if (i == 0) begin : g_first
                assign w_x   = r_nx[NORM_N-1];
                assign w_y   = r_ny[NORM_N-1];
                assign w_z   = '0;
                assign w_inv = r_ninv[NORM_N-1];
            end else begin : g_next
                assign w_x   = r_x[i-1];
                assign w_y   = r_y[i-1];
                assign w_z   = r_z[i-1];
                assign w_inv = r_inv[i-1];
            end

            assign w_xs = w_x >>> i;
            assign w_ys = w_y >>> i;

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    if (!w_y[XY_W-1]) begin
                        r_x[i] <= w_x + w_ys;
                        r_y[i] <= w_y - w_xs;
                        r_z[i] <= w_z + ANG;
                    end else begin
                        r_x[i] <= w_x - w_ys;
                        r_y[i] <= w_y + w_xs;
                        r_z[i] <= w_z - ANG;
                    end
                    r_inv[i] <= w_inv;
                end
            end
        end
    endgenerate

    assign o_valid   = r_v[DEPTH-1];
    assign o_z       = r_z[ITERATIONS-1];
    assign o_invalid = r_inv[ITERATIONS-1];

endmodule

`default_nettype wire

[src/bla_conv.sv]
`default_nettype none

module bla_conv (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_ce,
    input  logic                                i_valid,
    input  logic signed [bla_pkg::Z_W-1:0]      i_z,
    input  logic                                i_invalid,
    output logic                                o_valid,
    output logic signed [bla_pkg::PITCH_W-1:0]  o_pitch,
    output logic                                o_invalid
);
    import bla_pkg::*;

    logic [1:0]         r_v;
    logic [MAG_W-1:0]   r_mag;
    logic               r1_zneg, r1_inv;
    logic [PROD_W-1:0]  r_prod;
    logic               r2_zneg, r2_inv;

    logic [Z_W-1:0]     w_abs;
    logic [PROD_W-1:0]  w_sum;
    logic [DEG_W-1:0]   w_deg;
    logic signed [PITCH_W-1:0] w_degs;

    assign w_abs = i_z[Z_W-1] ? Z_W'(-i_z) : Z_W'(i_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_mag   <= w_abs[MAG_W-1:0];
            r1_zneg <= i_z[Z_W-1];
            r1_inv  <= i_invalid;
            // radians q30 to 1/256 degree
            r_prod  <= PROD_W'(r_mag) * PROD_W'(DEG_SCALE);
            r2_zneg <= r1_zneg;
            r2_inv  <= r1_inv;
        end
    end

    assign w_sum  = r_prod + (PROD_W'(1) << 45);
    assign w_deg  = w_sum[46 +: DEG_W];
    assign w_degs = $signed(PITCH_W'(w_deg));

    assign o_valid   = r_v[1];
    assign o_invalid = r2_inv;
    assign o_pitch   = r2_inv  ? PITCH_BAD :
                       r2_zneg ? PITCH_RIGHT + w_degs : PITCH_RIGHT - w_degs;

endmodule

`default_nettype wire

[src/ballistic_launch_angle.sv]
// Low-trajectory launch angle solver. Give a distance (1/16 cm) and a launch
// speed (1/256 m/s); the block returns the pitch from vertical in 1/256
// degree, or invalid with pitch -256 when the distance is zero or the target
// is out of reach for the configured height difference (mm, signed). One
// transfer is taken every clock cycle unless a held output stalls the
// pipeline. A result passes the 5-stage radicand front end, the 38-stage
// bit-per-stage square root, 6 stages of setup and scaling before the
// CORDIC, one CORDIC stage per iteration, 2 conversion stages and the
// output register. Write the height only while the block is idle.
`default_nettype none

module ballistic_launch_angle #(
    parameter int ITERATIONS = bla_pkg::BLA_ITERATIONS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [bla_pkg::DIST_W-1:0]          i_distance,
    input  logic [bla_pkg::SPEED_W-1:0]         i_speed,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [bla_pkg::PITCH_W-1:0]  o_pitch,
    output logic                                o_invalid,
    input  logic                                i_cfg_wr_en,
    input  logic [bla_pkg::HGT_W-1:0]           i_cfg_wr_data
);
    import bla_pkg::*;

    logic [HGT_W-1:0] r_height;

    logic                   w_ce;
    logic                   w_f_v, w_s_v, w_c_v, w_o_v;
    logic [RAD_W-1:0]       w_rad;
    t_side                  w_f_side, w_s_side;
    logic [ROOT_W-1:0]      w_root;
    logic signed [Z_W-1:0]  w_z;
    logic                   w_c_inv, w_o_inv;
    logic signed [PITCH_W-1:0] w_o_pitch;

    logic                      r_out_v;
    logic signed [PITCH_W-1:0] r_pitch;
    logic                      r_inv;

    // pipeline advances unless the output is held and a result waits behind it
    assign w_ce    = ~(r_out_v & ~i_ready & w_o_v);
    assign o_ready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= '0;
        end else if (i_cfg_wr_en) begin
            r_height <= i_cfg_wr_data;
        end
    end

    bla_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ce       (w_ce),
        .i_valid    (i_valid),
        .i_distance (i_distance),
        .i_speed    (i_speed),
        .i_height   (r_height),
        .o_valid    (w_f_v),
        .o_rad      (w_rad),
        .o_side     (w_f_side)
    );

    bla_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_f_v),
        .i_rad   (w_rad),
        .i_side  (w_f_side),
        .o_valid (w_s_v),
        .o_root  (w_root),
        .o_side  (w_s_side)
    );

    bla_cordic #(
        .ITERATIONS (ITERATIONS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ce      (w_ce),
        .i_valid   (w_s_v),
        .i_root    (w_root),
        .i_side    (w_s_side),
        .o_valid   (w_c_v),
        .o_z       (w_z),
        .o_invalid (w_c_inv)
    );

    bla_conv u_conv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ce      (w_ce),
        .i_valid   (w_c_v),
        .i_z       (w_z),
        .i_invalid (w_c_inv),
        .o_valid   (w_o_v),
        .o_pitch   (w_o_pitch),
        .o_invalid (w_o_inv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (~r_out_v | i_ready) begin
            r_out_v <= w_o_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (~r_out_v | i_ready) begin
            r_pitch <= w_o_pitch;
            r_inv   <= w_o_inv;
        end
    end

    assign o_valid   = r_out_v;
    assign o_pitch   = r_pitch;
    assign o_invalid = r_inv;

    a_inv_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> o_pitch == PITCH_BAD)
        else $error("invalid result without the invalid pitch");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_invalid |-> (o_pitch >= 17'sd0 && o_pitch <= 17'sd46080))
        else $error("valid pitch out of range");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready && w_o_v |-> !o_ready)
        else $error("input taken while the pipeline is full and stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

endmodule

`default_nettype wire
